### src/spms_pkg.sv
// spms_pkg: constants, status codes and pointer helpers for the shared-pool stack block.
// Depends on nothing; used by shared_pool_multi_stack and spms_chk.
`default_nettype none
package spms_pkg;

    localparam int NUM_STACKS = 8;
    localparam int POOL_SIZE  = 256;
    localparam int DATA_W     = 32;
    localparam int NUM_W      = 4;
    localparam int PTR_W      = $clog2(POOL_SIZE + 1);
    localparam int IDX_W      = $clog2(POOL_SIZE);
    localparam int STK_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int WORD_W     = PTR_W + DATA_W;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SIZE);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    function automatic logic [PTR_W-1:0] clean_ptr(input logic [PTR_W-1:0] p);
        return (p < PTR_W'(POOL_SIZE)) ? p : NULL_PTR;
    endfunction

endpackage
`default_nettype wire

### src/shared_pool_multi_stack.sv
// shared_pool_multi_stack: LIFO stacks sharing one slot pool, linked list plus free list.
// Depends on spms_pkg; one synchronous memory holds {link, data} per slot.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  command   | start, busy (out)       | i_action, i_stack_number, i_push_value
//  result    | o_valid strobe          | o_status, o_pop_value
//
// Each transfer reads the slot word from the pool memory when the command is accepted,
// then modifies it and writes it back while busy is high.
// The result strobe comes in the cycle after busy and overlaps the next command.
// Reset (synchronous) empties all stacks and chains the pool through a fill count,
// so no memory clearing pass is needed. The receiver cannot stall.
`default_nettype none
module shared_pool_multi_stack (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_action,
    input  wire logic [spms_pkg::NUM_W-1:0]      i_stack_number,
    input  wire logic signed [spms_pkg::DATA_W-1:0] i_push_value,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic signed [spms_pkg::DATA_W-1:0]   o_pop_value
);

    localparam int PTR_W  = spms_pkg::PTR_W;
    localparam int IDX_W  = spms_pkg::IDX_W;
    localparam int STK_W  = spms_pkg::STK_W;
    localparam int DATA_W = spms_pkg::DATA_W;
    localparam int WORD_W = spms_pkg::WORD_W;

    logic [WORD_W-1:0] mem [spms_pkg::POOL_SIZE];

    logic [PTR_W-1:0]      r_tops [spms_pkg::NUM_STACKS];
    logic [PTR_W-1:0]      r_free;
    logic [PTR_W-1:0]      r_fill;
    logic                  r_busy;
    logic                  r_action;
    logic [STK_W-1:0]      r_stk;
    logic [DATA_W-1:0]     r_value;
    spms_pkg::t_status     r_stat;
    logic [IDX_W-1:0]      r_addr;
    logic [WORD_W-1:0]     r_rd;
    logic                  r_valid;
    logic [1:0]            r_status;
    logic [DATA_W-1:0]     r_pop;

    logic                  acc;
    logic                  stk_ok;
    logic [STK_W-1:0]      stk_idx;
    logic [PTR_W-1:0]      top_ptr;
    spms_pkg::t_status     n_stat;
    logic [IDX_W-1:0]      n_addr;
    logic                  untouched;
    logic [PTR_W-1:0]      link_rd;
    logic [DATA_W-1:0]     data_rd;
    logic                  wb;
    logic [WORD_W-1:0]     wdata;

    assign acc     = start && !r_busy;
    assign stk_ok  = (i_stack_number != '0) &&
                     (i_stack_number <= spms_pkg::NUM_W'(spms_pkg::NUM_STACKS));
    assign stk_idx = STK_W'(i_stack_number - spms_pkg::NUM_W'(1));
    assign top_ptr = spms_pkg::clean_ptr(r_tops[stk_idx]);

    always_comb begin
        if (!stk_ok) begin
            n_stat = spms_pkg::ST_INVALID;
        end else if (!i_action) begin
            n_stat = (spms_pkg::clean_ptr(r_free) == spms_pkg::NULL_PTR) ?
                     spms_pkg::ST_FULL : spms_pkg::ST_OK;
        end else begin
            n_stat = (top_ptr == spms_pkg::NULL_PTR) ? spms_pkg::ST_EMPTY : spms_pkg::ST_OK;
        end
        n_addr = i_action ? top_ptr[IDX_W-1:0] : r_free[IDX_W-1:0];
    end

    // slots at or above the fill count were never written: they chain to the next index
    assign untouched = ({1'b0, r_addr} >= r_fill);
    assign link_rd   = untouched ? ({1'b0, r_addr} + PTR_W'(1))
                                 : spms_pkg::clean_ptr(r_rd[WORD_W-1:DATA_W]);
    assign data_rd   = r_rd[DATA_W-1:0];
    assign wb        = r_busy && (r_stat == spms_pkg::ST_OK);
    assign wdata     = r_action ? {spms_pkg::clean_ptr(r_free), data_rd}
                                : {spms_pkg::clean_ptr(r_tops[r_stk]), r_value};

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= mem[n_addr];
        end
        if (wb) begin
            mem[r_addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_action <= i_action;
            r_stk    <= stk_idx;
            r_value  <= i_push_value;
            r_stat   <= n_stat;
            r_addr   <= n_addr;
        end
        if (r_busy) begin
            r_status <= r_stat;
            r_pop    <= (wb && r_action) ? data_rd : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < spms_pkg::NUM_STACKS; i++) begin
                r_tops[i] <= spms_pkg::NULL_PTR;
            end
            r_free  <= '0;
            r_fill  <= '0;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
            if (acc) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (wb) begin
                if (!r_action) begin
                    r_free        <= link_rd;
                    r_tops[r_stk] <= {1'b0, r_addr};
                    if (untouched) begin
                        r_fill <= r_fill + PTR_W'(1);
                    end
                end else begin
                    r_tops[r_stk] <= link_rd;
                    r_free        <= {1'b0, r_addr};
                end
            end
        end
    end

    assign busy        = r_busy;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop;

endmodule
`default_nettype wire

### src/spms_chk.sv
// spms_chk: port-level checks on command/result timing and result payload.
// Depends on spms_pkg; bound to shared_pool_multi_stack at the end of this file.
`default_nettype none
module spms_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [1:0]                    o_status,
    input wire logic [spms_pkg::DATA_W-1:0]   o_pop_value
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("transfer accepted without going busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid)
        else $error("busy phase did not end in a result");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != spms_pkg::ST_OK) |-> (o_pop_value == '0))
        else $error("nonzero value on failed transfer");

endmodule

bind shared_pool_multi_stack spms_chk u_spms_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_pop_value (o_pop_value)
);
`default_nettype wire

### tb/sv/tb_shared_pool_multi_stack.sv
// tb_shared_pool_multi_stack: pushes and pops on the shared-pool stacks with random gaps, and
// checks every result strobe against an in-bench model of the stacks, slot links and free list.
// Depends on spms_pkg and shared_pool_multi_stack.
module tb_shared_pool_multi_stack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit ACT_PUSH       = 1'b0;
    localparam bit ACT_POP        = 1'b1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_OPS     = 120;

    typedef struct packed {
        spms_pkg::t_status                  status;
        logic signed [spms_pkg::DATA_W-1:0] value;
    } t_stack_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               i_action = ACT_PUSH;
    logic [spms_pkg::NUM_W-1:0]         i_stack_number = '0;
    logic signed [spms_pkg::DATA_W-1:0] i_push_value = '0;
    logic                               busy;
    logic                               o_valid;
    logic [1:0]                         o_status;
    logic signed [spms_pkg::DATA_W-1:0] o_pop_value;

    logic [spms_pkg::DATA_W-1:0] slot_data [spms_pkg::POOL_SIZE];
    logic [spms_pkg::PTR_W-1:0]  slot_link [spms_pkg::POOL_SIZE];
    logic [spms_pkg::PTR_W-1:0]  top_of [spms_pkg::NUM_STACKS];
    logic [spms_pkg::PTR_W-1:0]  free_head;
    int                          depth [spms_pkg::NUM_STACKS];

    t_stack_result pending_results [$];
    bit            burst_mode = 1'b0;
    int            mismatches = 0;
    int            idle_cycles = 0;

    shared_pool_multi_stack i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_stack_number (i_stack_number),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_pop_value    (o_pop_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic void reset_pool();
        for (int i = 0; i < spms_pkg::POOL_SIZE; i++) begin
            slot_data[i] = '0;
            slot_link[i] = (i == spms_pkg::POOL_SIZE - 1) ? spms_pkg::NULL_PTR
                                                          : spms_pkg::PTR_W'(i + 1);
        end
        for (int s = 0; s < spms_pkg::NUM_STACKS; s++) begin
            top_of[s] = spms_pkg::NULL_PTR;
            depth[s]  = 0;
        end
        free_head = '0;
    endfunction

    function automatic t_stack_result apply_stack_op(bit act,
                                                     logic [spms_pkg::NUM_W-1:0] num,
                                                     logic [spms_pkg::DATA_W-1:0] value);
        t_stack_result              r;
        int                         s;
        logic [spms_pkg::PTR_W-1:0] slot;
        r.status = spms_pkg::ST_OK;
        r.value  = '0;
        if (num == 0 || num > spms_pkg::NUM_STACKS) begin
            r.status = spms_pkg::ST_INVALID;
        end else begin
            s = num - 1;
            if (act == ACT_PUSH) begin
                if (free_head == spms_pkg::NULL_PTR) begin
                    r.status = spms_pkg::ST_FULL;
                end else begin
                    slot      = free_head;
                    free_head = slot_link[slot[spms_pkg::IDX_W-1:0]];
                    slot_data[slot[spms_pkg::IDX_W-1:0]] = value;
                    slot_link[slot[spms_pkg::IDX_W-1:0]] = top_of[s];
                    top_of[s] = slot;
                    depth[s]++;
                end
            end else begin
                if (top_of[s] == spms_pkg::NULL_PTR) begin
                    r.status = spms_pkg::ST_EMPTY;
                end else begin
                    slot      = top_of[s];
                    top_of[s] = slot_link[slot[spms_pkg::IDX_W-1:0]];
                    slot_link[slot[spms_pkg::IDX_W-1:0]] = free_head;
                    free_head = slot;
                    r.value   = slot_data[slot[spms_pkg::IDX_W-1:0]];
                    depth[s]--;
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (burst_mode || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [spms_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [spms_pkg::NUM_W-1:0] rand_stack();
        return spms_pkg::NUM_W'($urandom_range(1, spms_pkg::NUM_STACKS));
    endfunction

    function automatic logic [spms_pkg::NUM_W-1:0] bad_stack();
        int r;
        r = $urandom_range(0, 15 - spms_pkg::NUM_STACKS);
        return (r == 0) ? spms_pkg::NUM_W'(0) : spms_pkg::NUM_W'(spms_pkg::NUM_STACKS + r);
    endfunction

    // hold the command until it transfers, then record what it should return
    task automatic send_cmd(bit act, logic [spms_pkg::NUM_W-1:0] num,
                            logic [spms_pkg::DATA_W-1:0] value);
        int gap;
        start          <= 1'b1;
        i_action       <= act;
        i_stack_number <= num;
        i_push_value   <= value;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_stack_op(act, num, value));
        gap = gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        send_cmd(ACT_POP, 4'd1, '0);
        send_cmd(ACT_POP, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), '0);
        send_cmd(ACT_PUSH, 4'd0, 32'h1234_5678);
        send_cmd(ACT_POP, 4'd0, '0);
        send_cmd(ACT_PUSH, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS + 1), 32'h0000_0001);
        send_cmd(ACT_POP, 4'd15, 32'hffff_ffff);
        send_cmd(ACT_PUSH, 4'd15, 32'hffff_ffff);
        send_cmd(ACT_PUSH, 4'd1, 32'h7fff_ffff);
        send_cmd(ACT_PUSH, 4'd1, 32'h8000_0000);
        send_cmd(ACT_PUSH, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), 32'h0000_0000);
        send_cmd(ACT_PUSH, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), 32'hffff_ffff);
        send_cmd(ACT_PUSH, 4'd1, 32'h5555_aaaa);
        send_cmd(ACT_POP, 4'd1, 32'hffff_ffff);
        send_cmd(ACT_POP, 4'd1, '0);
        send_cmd(ACT_POP, 4'd1, '0);
        send_cmd(ACT_POP, 4'd1, '0);
        send_cmd(ACT_POP, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), '0);
        send_cmd(ACT_POP, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), '0);
        send_cmd(ACT_POP, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), '0);
    endtask

    task automatic test_pool_full();
        int s;
        repeat (spms_pkg::POOL_SIZE) send_cmd(ACT_PUSH, rand_stack(), rand_value());
        send_cmd(ACT_PUSH, 4'd1, rand_value());
        send_cmd(ACT_PUSH, spms_pkg::NUM_W'(spms_pkg::NUM_STACKS), rand_value());
        s = 0;
        while (depth[s] == 0) s++;
        send_cmd(ACT_POP, spms_pkg::NUM_W'(s + 1), '0);
        send_cmd(ACT_PUSH, rand_stack(), rand_value());
        send_cmd(ACT_PUSH, rand_stack(), rand_value());
    endtask

    task automatic test_random();
        int push_pct;
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 40 == 0) burst_mode = ($urandom_range(3) == 0);
            push_pct = ((i / 40) % 2 == 0) ? 30 : 70;
            if ($urandom_range(9) == 0)
                send_cmd(1'($urandom_range(1)), bad_stack(), rand_value());
            else if ($urandom_range(99) < push_pct)
                send_cmd(ACT_PUSH, rand_stack(), rand_value());
            else
                send_cmd(ACT_POP, rand_stack(), rand_value());
        end
        burst_mode = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %0d", o_status, o_pop_value);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_pop_value !== want.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result error: expected status %0d value %0d, got %0d %0d",
                                 want.status, want.value, o_status, o_pop_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("shared_pool_multi_stack: mismatch");
                $finish;
            end
        end
    end

    initial begin
        reset_pool();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pool_full();
        test_random();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("shared_pool_multi_stack: match");
        end else begin
            $display("shared_pool_multi_stack: mismatch");
        end
        $finish;
    end

endmodule
